@@ rtl/plk_pkg.sv @@
// ----------------------------------------------------------------------------
// plk_pkg
// Shared widths, request codes and state encoding for the power-law FIR.
// ----------------------------------------------------------------------------
package plk_pkg;

   // Default tap count of the filter.
   localparam int TAPS_DEFAULT = 256;

   // Payload widths.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int INDEX_W  = 8;
   localparam int OUT_W    = 24;

   // Product of an unsigned weight and a signed sample.
   localparam int PROD_W = COEF_W + SAMPLE_W + 1;

   // Rounding and output range in Q8.15.
   localparam int ROUND_SHIFT = 15;
   localparam int OUT_MAX     = 8388607;
   localparam int OUT_MIN     = -8388608;

   // Request function codes.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

@@ rtl/plk_if.sv @@
// ----------------------------------------------------------------------------
// plk_req_if / plk_rsp_if
// Valid/ready channels carrying filter requests and filter responses.
// ----------------------------------------------------------------------------
interface plk_req_if;
   import plk_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       func;
   logic signed [SAMPLE_W-1:0] sample;
   logic [INDEX_W-1:0]         coef_index;
   logic [COEF_W-1:0]          coef_value;

   modport source (output valid, func, sample, coef_index, coef_value, input ready);
   modport sink   (input valid, func, sample, coef_index, coef_value, output ready);
endinterface

interface plk_rsp_if;
   import plk_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] filtered;
   logic                    saturated;

   modport source (output valid, filtered, saturated, input ready);
   modport sink   (input valid, filtered, saturated, output ready);
endinterface

@@ rtl/power_law_kernel_fir_top.sv @@
// ----------------------------------------------------------------------------
// power_law_kernel_fir_top
// Causal FIR filter with programmable tap weights held in on-chip memory.
//
//   channel   dir   payload                                  note
//   req_chan  in    func, sample, coef_index, coef_value     sample or weight write
//   rsp_chan  out   filtered, saturated                      one per sample request
//
// A sample request runs one multiply-accumulate per tap, with one read of the
// weight memory and one of the history memory each cycle.
// A weight write gives no response.
// After reset a clearing pass zeroes the history memory; no request is taken
// during it.
// A finished response waits in an output register; a stalled response holds
// the next result back, while the next request can already be taken.
// ----------------------------------------------------------------------------
module power_law_kernel_fir_top #(
   parameter int TAPS = plk_pkg::TAPS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   plk_req_if.sink   req_chan,
   plk_rsp_if.source rsp_chan
);
   import plk_pkg::*;

   localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ACC_W = PROD_W + AW + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN  = ACC_W'(OUT_MIN);
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (ROUND_SHIFT - 1));

   // Storage: sample history and tap weights.
   logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
   logic [COEF_W-1:0]          wgt_mem  [TAPS];

   // Control registers.
   state_type      state_ff, state_in;
   logic [AW-1:0]  newest_ff, newest_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  tap_ff, tap_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic           rd_vld_ff, rd_vld_in;
   logic           prod_vld_ff, prod_vld_in;
   logic           rsp_vld_ff, rsp_vld_in;

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic [COEF_W-1:0]          wgt_rd_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [OUT_W-1:0]    out_ff, out_in;
   logic                       sat_ff, sat_in;

   // Handshake terms.
   logic req_fire, sample_fire, coef_fire, coef_in_range, issue, load_rsp;
   logic [AW-1:0] slot_next;
   logic signed [ACC_W-1:0] rounded;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign sample_fire    = req_fire && (req_chan.func == FUNC_SAMPLE);
   assign coef_fire      = req_fire && (req_chan.func == FUNC_COEF);
   assign coef_in_range  = (32'(req_chan.coef_index) < TAPS);
   assign issue          = (state_ff == ST_RUN);
   assign slot_next      = (newest_ff == LAST_ADDR) ? '0 : newest_ff + 1'b1;

   // Round half up to Q8.15 and clamp to the output range.
   assign rounded  = (acc_ff + ACC_HALF) >>> ROUND_SHIFT;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_chan.ready);

   always_comb begin
      if (rounded > ACC_MAX) begin
         out_in = OUT_W'(ACC_MAX);
         sat_in = 1'b1;
      end else if (rounded < ACC_MIN) begin
         out_in = OUT_W'(ACC_MIN);
         sat_in = 1'b1;
      end else begin
         out_in = OUT_W'(rounded);
         sat_in = 1'b0;
      end
   end

   // Sequencer and address counters.
   always_comb begin
      state_in  = state_ff;
      newest_in = newest_ff;
      clr_in    = clr_ff;
      tap_in    = tap_ff;
      pos_in    = pos_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (sample_fire) begin
               newest_in = slot_next;
               pos_in    = slot_next;
               tap_in    = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            tap_in = tap_ff + 1'b1;
            pos_in = (pos_ff == '0) ? LAST_ADDR : pos_ff - 1'b1;
            if (tap_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pipeline valid flags and output register flag.
   assign rd_vld_in   = issue;
   assign prod_vld_in = rd_vld_ff;
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_vld_in = 1'b1;
      end
   end

   // Multiply the weight, read as unsigned, by the signed sample.
   assign prod_in = $signed({1'b0, wgt_rd_ff}) * hist_rd_ff;

   // Accumulator restarts with each sample request.
   always_comb begin
      acc_in = acc_ff;
      if (sample_fire) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         newest_ff   <= '0;
         clr_ff      <= '0;
         tap_ff      <= '0;
         pos_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         newest_ff   <= newest_in;
         clr_ff      <= clr_in;
         tap_ff      <= tap_in;
         pos_ff      <= pos_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (load_rsp) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   // History memory: zeroed by the clearing pass, written by each new sample.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         hist_mem[clr_ff] <= '0;
      end else if (sample_fire) begin
         hist_mem[slot_next] <= req_chan.sample;
      end
      hist_rd_ff <= hist_mem[pos_ff];
   end

   // Weight memory: written by weight requests, indexes past the end are dropped.
   always_ff @(posedge clock) begin
      if (coef_fire && coef_in_range) begin
         wgt_mem[AW'(req_chan.coef_index)] <= req_chan.coef_value;
      end
      wgt_rd_ff <= wgt_mem[tap_ff];
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.filtered  = out_ff;
   assign rsp_chan.saturated = sat_ff;

endmodule
